>>> rtl/core/sks_pkg.sv
// Shared constants, codes and control types for the sorted unique key set.
`default_nettype none
package sks_pkg;
  localparam int DEPTH   = 64;
  localparam int KEY_W   = 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMD_W   = 3;
  localparam int ST_W    = 3;
  localparam int INDEX_W = 6;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_PRESENT = 3'd1;
  localparam logic [ST_W-1:0] ST_MISSING = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
  localparam logic [ST_W-1:0] ST_BADIDX  = 3'd4;

  typedef struct packed {
    logic capture;
    logic update;
    logic finish;
  } sks_ctl_t;
endpackage
`default_nettype wire

>>> rtl/core/sks_ctrl.sv
// Sequencer: capture, update and finish steps for each item.
`default_nettype none
module sks_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output sks_pkg::sks_ctl_t ctl
);
  import sks_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   done_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_UPD;
      S_UPD:  state_nxt = S_FIN;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == S_FIN);
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign done        = done_r;
  assign ctl.capture = start && (state_r == S_IDLE);
  assign ctl.update  = (state_r == S_UPD);
  assign ctl.finish  = (state_r == S_FIN);
endmodule
`default_nettype wire

>>> rtl/core/sks_dp.sv
// Datapath: chain of key cells with parallel compare, shift and result registers.
`default_nettype none
module sks_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sks_pkg::sks_ctl_t           ctl,
  input  logic [sks_pkg::CMD_W-1:0]   in_cmd,
  input  logic [sks_pkg::KEY_W-1:0]   in_key,
  input  logic [sks_pkg::INDEX_W-1:0] in_index,
  output logic [sks_pkg::ST_W-1:0]    res_status,
  output logic [sks_pkg::POS_W-1:0]   res_position,
  output logic [sks_pkg::KEY_W-1:0]   res_key_out,
  output logic [sks_pkg::COUNT_W-1:0] res_count,
  output logic [sks_pkg::KEY_W-1:0]   res_min_key,
  output logic [sks_pkg::KEY_W-1:0]   res_max_key
);
  import sks_pkg::*;

  logic [KEY_W-1:0] key_r [DEPTH];
  logic [KEY_W-1:0] prev_k [DEPTH];
  logic [KEY_W-1:0] next_k [DEPTH];
  logic [CNT_W-1:0] cnt_r;
  logic [CMD_W-1:0] op_r;
  logic [KEY_W-1:0] k_r;
  logic [IDX_W-1:0] idx_r;
  logic [DEPTH-1:0] lt_r, eq_r, lt_nxt, eq_nxt, first;
  logic [KEY_W-1:0] rd_r, rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             bad_r;
  logic [ST_W-1:0]  st_r, st_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [KEY_W-1:0] kout_r, kout_nxt;
  logic [IDX_W-1:0] found_pos, ins_pos;
  logic             any_eq, full, do_ins, do_rem;
  logic [ST_W-1:0]  o_status_r;
  logic [IDX_W-1:0] o_pos_r;
  logic [KEY_W-1:0] o_kout_r, o_min_r, o_max_r;
  logic [CNT_W-1:0] o_cnt_r;

  // one shared read port: requested index at capture, last entry at finish
  assign rd_addr = ctl.finish ? IDX_W'(cnt_r - 1'b1) : in_index[IDX_W-1:0];
  assign rd_data = key_r[rd_addr];

  genvar g;
  for (g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_k[g] = k_r;
    end else begin : g_body
      assign prev_k[g] = key_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign next_k[g] = key_r[g];
    end else begin : g_mid
      assign next_k[g] = key_r[g+1];
    end
    if (g == 0) begin : g_f0
      assign first[g] = !lt_r[g];
    end else begin : g_fn
      assign first[g] = !lt_r[g] && lt_r[g-1];
    end
    assign lt_nxt[g] = (CNT_W'(g) < cnt_r) && (key_r[g] < in_key);
    assign eq_nxt[g] = (CNT_W'(g) < cnt_r) && (key_r[g] == in_key);
  end

  always_comb begin
    found_pos = '0;
    ins_pos   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (eq_r[i]) found_pos = found_pos | IDX_W'(i);
      if (first[i]) ins_pos = ins_pos | IDX_W'(i);
    end
  end

  assign any_eq = |eq_r;
  assign full   = (cnt_r == CNT_W'(DEPTH));
  assign do_ins = ctl.update && (op_r == CMD_INSERT) && !any_eq && !full;
  assign do_rem = ctl.update && (op_r == CMD_REMOVE) && !bad_r;

  always_comb begin
    st_nxt   = ST_OK;
    pos_nxt  = '0;
    kout_nxt = '0;
    case (op_r)
      CMD_INSERT: begin
        if (any_eq) begin
          st_nxt  = ST_PRESENT;
          pos_nxt = found_pos;
        end else if (full) begin
          st_nxt = ST_FULL;
        end else begin
          pos_nxt = ins_pos;
        end
      end
      CMD_LOOKUP: begin
        if (any_eq) pos_nxt = found_pos;
        else st_nxt = ST_MISSING;
      end
      CMD_REMOVE, CMD_READ: begin
        if (bad_r) begin
          st_nxt = ST_BADIDX;
        end else begin
          pos_nxt  = idx_r;
          kout_nxt = rd_r;
        end
      end
      CMD_CLEAR: st_nxt = ST_OK;
      default:   st_nxt = ST_BADIDX;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (do_ins && !lt_r[i]) begin
        key_r[i] <= first[i] ? k_r : prev_k[i];
      end else if (do_rem && (IDX_W'(i) >= idx_r)) begin
        key_r[i] <= next_k[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (do_ins) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (do_rem) begin
      cnt_r <= cnt_r - 1'b1;
    end else if (ctl.update && (op_r == CMD_CLEAR)) begin
      cnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op_r  <= in_cmd;
      k_r   <= in_key;
      idx_r <= in_index[IDX_W-1:0];
      lt_r  <= lt_nxt;
      eq_r  <= eq_nxt;
      rd_r  <= rd_data;
      bad_r <= (CNT_W'(in_index) >= cnt_r);
    end
    if (ctl.update) begin
      st_r   <= st_nxt;
      pos_r  <= pos_nxt;
      kout_r <= kout_nxt;
    end
    if (ctl.finish) begin
      o_status_r <= st_r;
      o_pos_r    <= pos_r;
      o_kout_r   <= kout_r;
      o_cnt_r    <= cnt_r;
      o_min_r    <= (cnt_r != '0) ? key_r[0] : '0;
      o_max_r    <= (cnt_r != '0) ? rd_data : '0;
    end
  end

  assign res_status   = o_status_r;
  assign res_position = POS_W'(o_pos_r);
  assign res_key_out  = o_kout_r;
  assign res_count    = COUNT_W'(o_cnt_r);
  assign res_min_key  = o_min_r;
  assign res_max_key  = o_max_r;
endmodule
`default_nettype wire

>>> rtl/core/sorted_unique_key_set.sv
// Top level of the sorted unique key set: sequencer plus key cell datapath.
// Usage:
//   Holds up to 64 unique 32-bit keys in ascending order in a chain of cells.
//   An item (in_cmd, in_key, in_index) is taken at a rising edge with start
//   high and busy low. Commands: insert, lookup, remove at index, read at
//   index, clear.
//   All cells compare against the key in the accept cycle; the update step
//   shifts the cells for insert or remove; the finish step reads the largest
//   key through the single read port and loads the result registers.
//   The result shows on out_* for exactly one cycle with out_valid high,
//   once the finish step has loaded the result registers.
//   busy is high through the update and finish steps, so no new item is
//   taken while one is in flight; a new item may be accepted at the edge
//   that takes the previous result.
//   Every result carries status, position, key_out, count, min and max.
//   Reset (rst_n low, synchronous) empties the store and drops any item in
//   flight; cells are not cleared. The receiver cannot stall: out_valid is a
//   strobe and must be taken when it is shown.
`default_nettype none
module sorted_unique_key_set (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [sks_pkg::CMD_W-1:0]   in_cmd,
  input  logic [sks_pkg::KEY_W-1:0]   in_key,
  input  logic [sks_pkg::INDEX_W-1:0] in_index,
  output logic                        out_valid,
  output logic [sks_pkg::ST_W-1:0]    out_status,
  output logic [sks_pkg::POS_W-1:0]   out_position,
  output logic [sks_pkg::KEY_W-1:0]   out_key_out,
  output logic [sks_pkg::COUNT_W-1:0] out_count,
  output logic [sks_pkg::KEY_W-1:0]   out_min_key,
  output logic [sks_pkg::KEY_W-1:0]   out_max_key
);
  import sks_pkg::*;

  sks_ctl_t ctl;

  sks_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (out_valid),
    .ctl   (ctl)
  );

  sks_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .in_cmd       (in_cmd),
    .in_key       (in_key),
    .in_index     (in_index),
    .res_status   (out_status),
    .res_position (out_position),
    .res_key_out  (out_key_out),
    .res_count    (out_count),
    .res_min_key  (out_min_key),
    .res_max_key  (out_max_key)
  );

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result strobe missing three cycles after accept");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= COUNT_W'(DEPTH)))
    else $error("count beyond capacity");
`endif
endmodule
`default_nettype wire
